// File: hw/rtl/uvsmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsmm_pkg - shared types and codes for the unique value stack
// Command and status codes and the status bundle of the scan unit.
// ----------------------------------------------------------------------------
package uvsmm_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic signed [31:0] NEG_ONE32 = -32'sd1;
  localparam logic signed [4:0]  NEG_ONE5  = -5'sd1;

  // status of one scan pass over the stored entries
  typedef struct packed {
    logic               done;   // one-cycle pulse at end of pass
    logic               found;  // key matched some scanned entry
    logic               have;   // at least one entry scanned
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } scan_stat_t;

endpackage

// File: hw/rtl/uvsmm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsmm_if - command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface uvsmm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface uvsmm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] min_item;
  logic signed [31:0] max_item;
  logic signed [4:0]  position;

  modport source (output valid, output status, output count, output min_item,
                  output max_item, output position, input ready);
  modport sink   (input valid, input status, input count, input min_item,
                  input max_item, input position, output ready);
endinterface

// File: hw/rtl/unique_value_stack_min_max_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_stack_min_max_top - duplicate-free LIFO with min/max report
// Push, pop and find on a bounded stack of signed 32-bit values; each
// command beat yields one result beat with status, count, min, max, position.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                       beat
//  in_ch    in   cmd[1:0], value[31:0]                         one command
//  out_ch   out  status, count[4:0], min_item, max_item,       one result
//                position[4:0]
//
//  Sweep: with n entries to sweep (count before the command, one less for
//  a pop on a non-empty stack), the result is loaded when the sweep is
//  done; the next command is taken in the cycle after that. The sweep reads
//  the entry RAM, which has one write port and one registered read port,
//  one entry per cycle.
//  Reset (rst, synchronous) empties the stack; entries are not cleared.
//  A finished result sits in the output register; a new command is taken
//  while it waits, and only the final step stalls if it is still not taken.
//
module unique_value_stack_min_max_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  uvsmm_in_if.sink    in_ch,
  uvsmm_out_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_next;
  logic [1:0]         cmd;
  logic signed [31:0] val;

  // scan unit hookup
  logic                  start;
  logic [CW-1:0]         scan_n;
  logic                  we;
  uvsmm_pkg::scan_stat_t stat;
  logic [AW-1:0]         pos;

  // result in flight
  logic               out_valid;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] min_item;
  logic signed [31:0] max_item;
  logic signed [4:0]  position;
  logic [1:0]         status_next;
  logic signed [31:0] min_next;
  logic signed [31:0] max_next;
  logic signed [4:0]  position_next;
  logic [31:0]        pos_wide;
  logic [31:0]        fill_wide;

  logic accept;
  logic load;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept;
  // a pop leaves the top entry out of the sweep
  assign scan_n = (in_ch.cmd == uvsmm_pkg::CMD_POP && fill != '0) ? fill - 1'b1 : fill;

  uvsmm_scan #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .n     (scan_n),
    .key   (in_ch.value),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata (val),
    .stat  (stat),
    .pos   (pos)
  );

  assign load = (state == S_FIN) && (!out_valid || out_ch.ready);

  // result of the command once the sweep is in
  always_comb begin
    status_next   = uvsmm_pkg::ST_OK;
    fill_next     = fill;
    we            = 1'b0;
    min_next      = stat.have ? stat.lo : uvsmm_pkg::NEG_ONE32;
    max_next      = stat.have ? stat.hi : uvsmm_pkg::NEG_ONE32;
    pos_wide      = 32'(pos);
    position_next = uvsmm_pkg::NEG_ONE5;
    case (cmd)
      uvsmm_pkg::CMD_PUSH: begin
        if (stat.found) begin
          status_next = uvsmm_pkg::ST_DUP;
        end else if (32'(fill) >= 32'(DEPTH)) begin
          status_next = uvsmm_pkg::ST_FULL;
        end else begin
          we        = load;
          fill_next = fill + 1'b1;
          min_next  = (!stat.have || val < stat.lo) ? val : stat.lo;
          max_next  = (!stat.have || val > stat.hi) ? val : stat.hi;
        end
      end
      uvsmm_pkg::CMD_POP: begin
        if (fill == '0) begin
          status_next = uvsmm_pkg::ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      uvsmm_pkg::CMD_FIND: begin
        if (stat.found) begin
          position_next = pos_wide[4:0];
        end
      end
      default: begin
      end
    endcase
    fill_wide = 32'(fill_next);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.done) state_next = S_FIN;
      end
      S_FIN: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_ch.cmd;
      val <= in_ch.value;
    end
    if (load) begin
      status   <= status_next;
      count    <= fill_wide[4:0];
      min_item <= min_next;
      max_item <= max_next;
      position <= position_next;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = status;
  assign out_ch.count    = count;
  assign out_ch.min_item = min_item;
  assign out_ch.max_item = max_item;
  assign out_ch.position = position;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(DEPTH))
    else $error("fill count above DEPTH");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN))
    else $error("command accepted but sweep not started");

  a_fill_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(fill))
    else $error("fill count moved outside the finish step");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result loaded but not offered");

  a_write_only_push: assert property (@(posedge clk) disable iff (rst)
    we |-> (cmd == uvsmm_pkg::CMD_PUSH && !stat.found && load))
    else $error("entry write outside an accepted push");
`endif

endmodule

// File: hw/rtl/uvsmm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsmm_scan - entry memory and scan unit
// Holds the stack entries in a RAM with a registered read and sweeps the lowest n
// entries, tracking key match, first match index, minimum and maximum.
// ----------------------------------------------------------------------------
module uvsmm_scan #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CW-1:0]         n,
  input  logic signed [31:0]    key,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic signed [31:0]    wdata,
  output uvsmm_pkg::scan_stat_t stat,
  output logic [AW-1:0]         pos
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  logic               busy;
  logic [CW-1:0]      rd_cnt;
  logic [CW-1:0]      n_r;
  logic signed [31:0] key_r;
  logic               rd_vld;
  logic [AW-1:0]      rd_pos;
  logic               found;
  logic               have;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic               issue;
  logic               done;

  assign issue = busy && (rd_cnt < n_r);
  assign done  = busy && (rd_cnt == n_r) && !rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_vld <= 1'b0;
      rd_cnt <= '0;
      found  <= 1'b0;
      have   <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      rd_vld <= 1'b0;
      rd_cnt <= '0;
      found  <= 1'b0;
      have   <= 1'b0;
    end else if (busy) begin
      rd_vld <= issue;
      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (rd_vld) begin
        have <= 1'b1;
        if (rdata == key_r) begin
          found <= 1'b1;
        end
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      key_r <= key;
    end
    if (issue) begin
      rd_pos <= rd_cnt[AW-1:0];
    end
    if (busy && rd_vld) begin
      if (!found && rdata == key_r) begin
        pos <= rd_pos;
      end
      if (!have || rdata < lo) begin
        lo <= rdata;
      end
      if (!have || rdata > hi) begin
        hi <= rdata;
      end
    end
  end

  assign stat.done  = done;
  assign stat.found = found;
  assign stat.have  = have;
  assign stat.lo    = lo;
  assign stat.hi    = hi;

endmodule
